/* hw/rtl/whp_pkg.sv */
// Package for the WAV header parser: phase and status codes, chunk tags.
`timescale 1ns / 1ps

package whp_pkg;

  // Four-character tags as they stand in the little-endian byte shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_BEXT = 32'h7478_6562;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] ENC_PCM  = 16'h0001;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_CHUNKHDR,
    PH_SKIP,
    PH_FMT,
    PH_PAYLOAD,
    PH_TRAIL,
    PH_HALT
  } phase_e;

  typedef enum logic [3:0] {
    ST_HEADER   = 4'd0,
    ST_DONE     = 4'd1,
    ST_PAYLOAD  = 4'd2,
    ST_TRAIL    = 4'd3,
    ST_NORIFF   = 4'd4,
    ST_NOWAVE   = 4'd5,
    ST_NOFMT    = 4'd6,
    ST_FMTSHORT = 4'd7,
    ST_NOTPCM   = 4'd8,
    ST_BADBITS  = 4'd9,
    ST_NODATA   = 4'd10,
    ST_HALTED   = 4'd11
  } status_e;

  function automatic logic is_skippable(input logic [31:0] tag);
    return (tag == TAG_FACT) || (tag == TAG_LIST) || (tag == TAG_BEXT) || (tag == TAG_JUNK);
  endfunction

endpackage

/* hw/rtl/whp_if.sv */
// Stream interfaces of the WAV header parser: input bytes and per-byte results.
`timescale 1ns / 1ps

interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic        sample_format;
  logic [31:0] data_length;

  modport source (
    output valid, output status, output payload_byte, output last_payload,
    output channel_count, output sample_rate, output sample_format,
    output data_length, input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input last_payload,
    input channel_count, input sample_rate, input sample_format,
    input data_length, output ready
  );
endinterface

/* hw/rtl/wav_header_parser_core.sv */
// WAV header parser top level: byte-stream RIFF/WAVE PCM header parser.
`timescale 1ns / 1ps

// Streaming RIFF/WAVE parser. Feed the file one byte per transaction on in_i,
// with first_byte set on the first byte of each file; every input byte yields
// exactly one result transaction on out_o. The parser checks the RIFF and WAVE
// tags, skips fact/LIST/bext/JUNK chunks by their size, reads the 16-byte fmt
// body (PCM, 8 or 16 bits only), then finds the data chunk and passes its bytes
// through with status payload, flagging the final one. Anything after the data
// chunk is reported as trailing; the first error gets its own code and every
// later byte reads halted until first_byte restarts the parser. Throughput is
// one byte per clock while out_o is ready. An accepted byte waits in the input
// register while the parse state (32-bit counter, shift register and fmt
// fields) is updated and the result is formed, then moves on into the result
// register, from which its result is offered on out_o until it is taken.
// Both registers advance together whenever the result register is empty or
// being taken, so a stalled sink holds at most one byte in each.

module wav_header_parser_core
  import whp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  whp_in_if.sink     in_i,
  whp_out_if.source  out_o
);

  // Pipeline control
  logic advance;    // result register free to load
  logic step;       // input register holds a byte that moves on this cycle

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;

  // Parse state
  phase_e      phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] clen_q, clen_d;
  logic [15:0] enc_q, enc_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] left_q, left_d;
  logic        seek_data_q, seek_data_d;
  logic        len_known_q, len_known_d;

  // Result
  status_e    status_d;
  logic [7:0] pay_d;
  logic       last_d;

  logic        out_valid_q;
  logic [3:0]  status_q;
  logic [7:0]  pay_q;
  logic        last_q;
  logic [15:0] out_chans_q;
  logic [31:0] out_rate_q;
  logic        out_fmt_q;
  logic [31:0] out_len_q;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_first_q <= in_i.first_byte;
    end
  end

  // Parse step. A first byte restarts from reset values before it is parsed.
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    shift_d     = shift_q;
    tag_d       = tag_q;
    clen_d      = clen_q;
    enc_d       = enc_q;
    chans_d     = chans_q;
    rate_d      = rate_q;
    bits_d      = bits_q;
    left_d      = left_q;
    seek_data_d = seek_data_q;
    len_known_d = len_known_q;
    status_d    = ST_HEADER;
    pay_d       = 8'd0;
    last_d      = 1'b0;

    if (in_first_q) begin
      phase_d     = PH_FILEHDR;
      count_d     = '0;
      shift_d     = '0;
      tag_d       = '0;
      clen_d      = '0;
      enc_d       = '0;
      chans_d     = '0;
      rate_d      = '0;
      bits_d      = '0;
      left_d      = '0;
      seek_data_d = 1'b0;
      len_known_d = 1'b0;
    end

    shift_d = {in_byte_q, shift_d[31:8]};

    case (phase_d)
      PH_FILEHDR: begin
        if (count_d == 32'd3 && shift_d != TAG_RIFF) begin
          status_d = ST_NORIFF;
          phase_d  = PH_HALT;
        end else if (count_d == 32'd11) begin
          if (shift_d != TAG_WAVE) begin
            status_d = ST_NOWAVE;
            phase_d  = PH_HALT;
          end else begin
            phase_d = PH_CHUNKHDR;
            count_d = '0;
          end
        end else begin
          count_d = count_d + 32'd1;
        end
      end

      PH_CHUNKHDR: begin
        if (count_d == 32'd3) begin
          tag_d   = shift_d;
          count_d = count_d + 32'd1;
        end else if (count_d == 32'd7) begin
          clen_d = shift_d;
          if (tag_d == (seek_data_d ? TAG_DATA : TAG_FMT)) begin
            if (clen_d == 32'd0) begin
              status_d = seek_data_d ? ST_NODATA : ST_NOFMT;
              phase_d  = PH_HALT;
            end else if (!seek_data_d) begin
              if (clen_d < FMT_BODY_LEN) begin
                status_d = ST_FMTSHORT;
                phase_d  = PH_HALT;
              end else begin
                phase_d = PH_FMT;
                count_d = '0;
              end
            end else begin
              left_d      = clen_d;
              len_known_d = 1'b1;
              phase_d     = PH_PAYLOAD;
              status_d    = ST_DONE;
            end
          end else if (is_skippable(tag_d)) begin
            if (clen_d == 32'd0) begin
              phase_d = PH_CHUNKHDR;
              count_d = '0;
            end else begin
              phase_d = PH_SKIP;
              count_d = clen_d;
            end
          end else begin
            status_d = seek_data_d ? ST_NODATA : ST_NOFMT;
            phase_d  = PH_HALT;
          end
        end else begin
          count_d = count_d + 32'd1;
        end
      end

      PH_SKIP: begin
        count_d = count_d - 32'd1;
        if (count_d == 32'd0) begin
          phase_d = PH_CHUNKHDR;
        end
      end

      PH_FMT: begin
        // fmt body: encoding, channels, rate, byte rate, align, bits
        if (count_d == 32'd1) begin
          enc_d = shift_d[31:16];
        end else if (count_d == 32'd3) begin
          chans_d = shift_d[31:16];
        end else if (count_d == 32'd7) begin
          rate_d = shift_d;
        end
        if (count_d == 32'd15) begin
          bits_d      = shift_d[31:16];
          seek_data_d = 1'b1;
          if (enc_d != ENC_PCM) begin
            status_d = ST_NOTPCM;
            phase_d  = PH_HALT;
          end else if (bits_d != 16'd8 && bits_d != 16'd16) begin
            status_d = ST_BADBITS;
            phase_d  = PH_HALT;
          end else if (clen_d > FMT_BODY_LEN) begin
            phase_d = PH_SKIP;
            count_d = clen_d - FMT_BODY_LEN;
          end else begin
            phase_d = PH_CHUNKHDR;
            count_d = '0;
          end
        end else begin
          count_d = count_d + 32'd1;
        end
      end

      PH_PAYLOAD: begin
        status_d = ST_PAYLOAD;
        pay_d    = in_byte_q;
        left_d   = left_d - 32'd1;
        if (left_d == 32'd0) begin
          last_d  = 1'b1;
          phase_d = PH_TRAIL;
        end
      end

      PH_TRAIL: begin
        status_d = ST_TRAIL;
      end

      default: begin
        status_d = ST_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FILEHDR;
      count_q     <= '0;
      shift_q     <= '0;
      tag_q       <= '0;
      clen_q      <= '0;
      enc_q       <= '0;
      chans_q     <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      left_q      <= '0;
      seek_data_q <= 1'b0;
      len_known_q <= 1'b0;
    end else if (step) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      tag_q       <= tag_d;
      clen_q      <= clen_d;
      enc_q       <= enc_d;
      chans_q     <= chans_d;
      rate_q      <= rate_d;
      bits_q      <= bits_d;
      left_q      <= left_d;
      seek_data_q <= seek_data_d;
      len_known_q <= len_known_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q    <= status_d;
      pay_q       <= pay_d;
      last_q      <= last_d;
      out_chans_q <= chans_d;
      out_rate_q  <= rate_d;
      out_fmt_q   <= (bits_d == 16'd16);
      out_len_q   <= len_known_d ? clen_d : 32'd0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.payload_byte  = pay_q;
  assign out_o.last_payload  = last_q;
  assign out_o.channel_count = out_chans_q;
  assign out_o.sample_rate   = out_rate_q;
  assign out_o.sample_format = out_fmt_q;
  assign out_o.data_length   = out_len_q;

  // Checks

  // The last_payload flag is only ever set on a payload transaction
  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> status_q == ST_PAYLOAD)
    else $error("last_payload outside payload");

  // Non-zero payload data only with payload status
  a_pay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pay_q != 8'd0 |-> status_q == ST_PAYLOAD)
    else $error("payload byte set outside payload");

  // Any error status parks the parser in halt
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (status_d == ST_NORIFF || status_d == ST_NOWAVE || status_d == ST_NOFMT ||
             status_d == ST_FMTSHORT || status_d == ST_NOTPCM ||
             status_d == ST_BADBITS || status_d == ST_NODATA)
    |=> phase_q == PH_HALT)
    else $error("error did not halt parser");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // Header done carries a non-zero data length
  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_DONE |-> out_len_q != 32'd0)
    else $error("header done with zero data length");

endmodule
